// ----- hdl/cit_pkg.sv -----
// shared types, constants and the microcode table of the catch-up interval timer
// used by cit_sequencer, cit_datapath and catchup_interval_timer_unit
// no dependencies
package cit_pkg;

  // catch-up limit per pulse and the firing counter width it needs
  localparam int unsigned MaxCatchup = 10;
  localparam int unsigned CntW       = $clog2(MaxCatchup + 1);

  // step counter
  localparam int unsigned PcW = 3;

  localparam logic [PcW-1:0] StepIdle     = PcW'(0);
  localparam logic [PcW-1:0] StepDispatch = PcW'(1);
  localparam logic [PcW-1:0] StepStatus   = PcW'(2);
  localparam logic [PcW-1:0] StepFire     = PcW'(3);
  localparam logic [PcW-1:0] StepEmit     = PcW'(4);

  // command codes
  localparam logic [1:0] CmdPulse = 2'd0;
  localparam logic [1:0] CmdStart = 2'd1;
  localparam logic [1:0] CmdKill  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CfgInterval = 2'd0;
  localparam logic [1:0] CfgRepeat   = 2'd1;
  localparam logic [1:0] CfgTrad     = 2'd2;

  // datapath action of one step
  typedef enum logic [1:0] {
    ActNone,
    ActCmd,
    ActFire
  } act_e;

  // result produced by one step
  typedef enum logic [1:0] {
    EmitNone,
    EmitFire,
    EmitStatus
  } emit_e;

  // branch condition of one step
  typedef enum logic [1:0] {
    JmpNever,
    JmpAlways,
    JmpFireStart,
    JmpMore
  } jcond_e;

  // one control word
  typedef struct packed {
    logic           in_rdy;
    act_e           act;
    emit_e          emit;
    jcond_e         jcond;
    logic [PcW-1:0] jtgt;
    logic [PcW-1:0] nxt;
  } uword_t;

  // qualified controls from sequencer to datapath
  typedef struct packed {
    logic  take;
    act_e  act;
    emit_e emit;
  } dp_ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic fire_start;
    logic more;
    logic out_free;
  } dp_stat_t;

  // microcode table
  function automatic uword_t ucode_rom(input logic [PcW-1:0] pc);
    uword_t w;
    w = '{in_rdy: 1'b0, act: ActNone, emit: EmitNone, jcond: JmpAlways,
          jtgt: StepIdle, nxt: StepIdle};
    unique case (pc)
      // wait for an input transfer
      StepIdle:     w = '{in_rdy: 1'b1, act: ActNone, emit: EmitNone,
                          jcond: JmpNever, jtgt: StepIdle, nxt: StepDispatch};
      // apply start/kill, branch into the firing loop on a due pulse
      StepDispatch: w = '{in_rdy: 1'b0, act: ActCmd, emit: EmitNone,
                          jcond: JmpFireStart, jtgt: StepFire, nxt: StepStatus};
      // single status result
      StepStatus:   w = '{in_rdy: 1'b0, act: ActNone, emit: EmitStatus,
                          jcond: JmpNever, jtgt: StepIdle, nxt: StepIdle};
      // one firing: advance time, count down repeats
      StepFire:     w = '{in_rdy: 1'b0, act: ActFire, emit: EmitNone,
                          jcond: JmpNever, jtgt: StepIdle, nxt: StepEmit};
      // firing result, loop while another firing is due
      StepEmit:     w = '{in_rdy: 1'b0, act: ActNone, emit: EmitFire,
                          jcond: JmpMore, jtgt: StepFire, nxt: StepIdle};
      default:      w = '{in_rdy: 1'b0, act: ActNone, emit: EmitNone,
                          jcond: JmpAlways, jtgt: StepIdle, nxt: StepIdle};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/catchup_interval_timer_unit.sv -----
// top level of the catch-up interval timer: microcoded sequencer plus datapath
// depends on cit_pkg, cit_sequencer and cit_datapath
//
// usage
//   s_axis: one transfer per command; tuser holds the command (pulse, start,
//   kill), tdata holds the current time in ticks. s_axis_tready_o is high only
//   in the idle step, so one item is processed at a time.
//   m_axis: one transfer per result; tuser is the fired flag, tdata[0] is the
//   alive flag, tlast marks the final result of an item.
//   cfg: register writes (interval, repeat count, traditional mode), always
//   ready, to be written only while no item is in flight.
// step sequence
//   a non-firing item passes the idle, dispatch and status steps; a pulse that
//   fires passes idle and dispatch, then one fire step and one emit step per
//   firing, set by the microprogram loop.
// reset
//   timer dead, time and repeats zero, configuration zero, no result pending.
// back pressure
//   an emitting step holds until the output register is free; the held result
//   stays stable until m_axis_tready_i takes it.
module catchup_interval_timer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] now
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] command
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [0] alive, [7:1] zero
  output logic        m_axis_tuser_o,   // [0] fired
  output logic        m_axis_tlast_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import cit_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;
  logic     out_alive;

  // step counter and microcode
  cit_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // timer state and result register
  cit_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (s_axis_tuser_i),
    .now_i       (s_axis_tdata_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_fired_o (m_axis_tuser_o),
    .out_alive_o (out_alive),
    .out_last_o  (m_axis_tlast_o)
  );

  // result packing
  assign m_axis_tdata_o = {7'b0, out_alive};
  assign cfg_ready_o    = 1'b1;

endmodule

// ----- hdl/cit_sequencer.sv -----
// step counter and branch logic reading the microcode table
// depends on cit_pkg
module cit_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cit_pkg::dp_stat_t  stat_i,
  output cit_pkg::dp_ctrl_t  ctrl_o
);
  import cit_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  uword_t         cw;
  logic           in_hold;
  logic           out_hold;
  logic           go;
  logic           jump;

  // fetch the control word
  assign cw = ucode_rom(pc_q);

  // a step holds while waiting for input or for the output slot
  assign in_hold  = cw.in_rdy && !in_valid_i;
  assign out_hold = (cw.emit != EmitNone) && !stat_i.out_free;
  assign go       = !in_hold && !out_hold;

  // branch condition
  always_comb begin
    case (cw.jcond)
      JmpAlways:    jump = 1'b1;
      JmpFireStart: jump = stat_i.fire_start;
      JmpMore:      jump = stat_i.more;
      default:      jump = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    pc_d = pc_q;
    if (go) begin
      pc_d = jump ? cw.jtgt : cw.nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

  // qualified controls
  assign in_ready_o  = cw.in_rdy;
  assign ctrl_o.take = cw.in_rdy && in_valid_i;
  assign ctrl_o.act  = go ? cw.act : ActNone;
  assign ctrl_o.emit = go ? cw.emit : EmitNone;

  // an accepted transfer is always followed by the dispatch step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.take |=> (pc_q == StepDispatch))
    else $error("input transfer not followed by dispatch");

  // results are only produced from the two emitting steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.emit != EmitNone) |-> (pc_q == StepStatus || pc_q == StepEmit))
    else $error("result emitted from a non-emitting step");

endmodule

// ----- hdl/cit_datapath.sv -----
// timer state, configuration registers, compare logic and output register
// depends on cit_pkg
module cit_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // input payload
  input  logic [1:0]         cmd_i,
  input  logic [31:0]        now_i,
  // sequencer link
  input  cit_pkg::dp_ctrl_t  ctrl_i,
  output cit_pkg::dp_stat_t  stat_o,
  // result register
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_fired_o,
  output logic               out_alive_o,
  output logic               out_last_o
);
  import cit_pkg::*;

  logic [31:0]     interval_q;
  logic [30:0]     repeat_q;
  logic            trad_q;
  logic [1:0]      cmd_q;
  logic [31:0]     now_q;
  logic [31:0]     last_q, last_d;
  logic [30:0]     rep_q, rep_d;
  logic            dead_q, dead_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     due_time;
  logic            due;
  logic [CntW-1:0] budget;
  logic            more;
  logic            oval_q, oval_d;
  logic            ofired_q, ofired_d;
  logic            oalive_q, oalive_d;
  logic            olast_q, olast_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
      repeat_q   <= '0;
      trad_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgInterval: interval_q <= cfg_data_i;
        CfgRepeat:   repeat_q   <= cfg_data_i[30:0];
        CfgTrad:     trad_q     <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  // captured input item
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      cmd_q <= cmd_i;
      now_q <= now_i;
    end
  end

  // due compare, sum wraps at 32 bits
  assign due_time = last_q + interval_q;
  assign due      = (now_q >= due_time);
  assign budget   = trad_q ? CntW'(1) : CntW'(MaxCatchup);
  assign more     = !dead_q && (cnt_q < budget) && due;

  assign stat_o.fire_start = (cmd_q == CmdPulse) && !dead_q && due;
  assign stat_o.more       = more;
  assign stat_o.out_free   = !oval_q || out_ready_i;

  // timer state update
  always_comb begin
    last_d = last_q;
    rep_d  = rep_q;
    dead_d = dead_q;
    cnt_d  = cnt_q;
    case (ctrl_i.act)
      ActCmd: begin
        cnt_d = '0;
        if (cmd_q == CmdStart) begin
          last_d = now_q;
          rep_d  = repeat_q;
          dead_d = 1'b0;
        end else if (cmd_q == CmdKill) begin
          dead_d = 1'b1;
        end
      end
      ActFire: begin
        cnt_d  = cnt_q + CntW'(1);
        last_d = trad_q ? now_q : due_time;
        if (rep_q != '0) begin
          rep_d = rep_q - 31'd1;
          if (rep_q == 31'd1) begin
            dead_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      rep_q  <= '0;
      dead_q <= 1'b1;
      cnt_q  <= '0;
    end else begin
      last_q <= last_d;
      rep_q  <= rep_d;
      dead_q <= dead_d;
      cnt_q  <= cnt_d;
    end
  end

  // output register, freed by a transfer and reloaded by an emitting step
  always_comb begin
    oval_d   = oval_q && !out_ready_i;
    ofired_d = ofired_q;
    oalive_d = oalive_q;
    olast_d  = olast_q;
    case (ctrl_i.emit)
      EmitFire: begin
        oval_d   = 1'b1;
        ofired_d = 1'b1;
        oalive_d = !dead_q;
        olast_d  = !more;
      end
      EmitStatus: begin
        oval_d   = 1'b1;
        ofired_d = 1'b0;
        oalive_d = !dead_q;
        olast_d  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else begin
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ofired_q <= ofired_d;
    oalive_q <= oalive_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o = oval_q;
  assign out_fired_o = ofired_q;
  assign out_alive_o = oalive_q;
  assign out_last_o  = olast_q;

  // firing count per pulse never passes the catch-up limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxCatchup))
    else $error("firing count beyond catch-up limit");

  // traditional mode fires once, so each firing result closes its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.emit == EmitFire && trad_q) |=> olast_q)
    else $error("second firing in traditional mode");

  // a firing that kills the timer is the final result of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oval_q && ofired_q && !oalive_q) |-> olast_q)
    else $error("firing result after timer died");

endmodule

// ----- tb/sv/tb_catchup_interval_timer_unit.sv -----
`timescale 1ns / 100ps
// self-checking testbench of catchup_interval_timer_unit: directed and random command streams
// with random idling on both streams; depends on cit_pkg and the timer rtl

module tb_catchup_interval_timer_unit;
  import cit_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned PhaseItems = 47;
  localparam int unsigned TailCycles = 40;
  localparam logic [1:0]  CmdUnknown = 2'd3;
  localparam logic [1:0]  CfgUnused  = 2'd3;

  // one result as seen on the master side
  typedef struct packed {
    logic fired;
    logic alive;
    logic fin;
  } timer_result_t;

  // predicted timer state and the firings still owed by the block
  class fire_board;
    logic [31:0]   interval;
    logic [30:0]   repeat_cfg;
    logic          trad;
    logic [31:0]   last_fire;
    logic [30:0]   reps_left;
    logic          dead;
    timer_result_t owed_q[$];
    int unsigned   mismatches;

    function new();
      interval   = '0;
      repeat_cfg = '0;
      trad       = 1'b0;
      last_fire  = '0;
      reps_left  = '0;
      dead       = 1'b1;
      mismatches = 0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [31:0] data);
      case (idx)
        CfgInterval: interval = data;
        CfgRepeat:   repeat_cfg = data[30:0];
        CfgTrad:     trad = data[0];
        default: begin
        end
      endcase
    endfunction

    // works out the results one accepted command causes
    function void take_command(input logic [1:0] cmd, input logic [31:0] now);
      logic [31:0]   due;
      logic          alive_seq [MaxCatchup];
      int unsigned   fires;
      int unsigned   budget;
      logic          stop;
      timer_result_t r;
      fires = 0;
      stop  = 1'b0;
      case (cmd)
        CmdStart: begin
          last_fire = now;
          reps_left = repeat_cfg;
          dead      = 1'b0;
        end
        CmdKill: dead = 1'b1;
        CmdPulse: begin
          if (!dead) begin
            budget = trad ? 1 : MaxCatchup;
            due    = last_fire + interval;
            // fire while due; the due time wraps modulo 2^32, the compare is unsigned
            while (fires < budget && !stop && now >= due) begin
              last_fire = trad ? now : due;
              if (reps_left != '0) begin
                reps_left = reps_left - 31'd1;
                if (reps_left == '0) begin
                  dead = 1'b1;
                  stop = 1'b1;
                end
              end
              alive_seq[fires] = !dead;
              fires++;
              due = last_fire + interval;
            end
          end
        end
        default: begin
        end
      endcase
      if (fires == 0) begin
        r = '{fired: 1'b0, alive: !dead, fin: 1'b1};
        owed_q.push_back(r);
      end else begin
        for (int unsigned k = 0; k < fires; k++) begin
          r = '{fired: 1'b1, alive: alive_seq[k], fin: (k == fires - 1)};
          owed_q.push_back(r);
        end
      end
    endfunction

    function void complain(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    // compares one result transfer with the oldest owed result
    function void match_result(input logic fired, input logic [7:0] data, input logic fin);
      timer_result_t want;
      logic [7:0]    want_data;
      if (owed_q.size() == 0) begin
        complain($sformatf("unexpected result: fired=%0b data=%02h last=%0b",
                           fired, data, fin));
      end else begin
        want      = owed_q.pop_front();
        want_data = {7'd0, want.alive};
        if (fired !== want.fired || data !== want_data || fin !== want.fin)
          complain($sformatf({"result mismatch: expected fired=%0b data=%02h last=%0b,",
                              " got fired=%0b data=%02h last=%0b"},
                             want.fired, want_data, want.fin, fired, data, fin));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_n;
  logic        s_tvalid;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tready;
  logic        cfg_valid;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [7:0]  m_axis_tdata_o;
  wire         m_axis_tuser_o;
  wire         m_axis_tlast_o;
  wire         cfg_ready_o;

  fire_board   board;
  logic        calm;
  int unsigned cycle_count = 0;

  catchup_interval_timer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones, none in calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_interval();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd0;
    if (r < 70) return $urandom_range(1, 20);
    if (r < 85) return $urandom_range(21, 1000);
    if (r < 92) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // bit 31 is outside the register and is driven at random
  function automatic logic [31:0] pick_repeat();
    int unsigned r;
    logic [30:0] v;
    r = $urandom_range(0, 99);
    if (r < 35) v = '0;
    else if (r < 85) v = 31'($urandom_range(1, 6));
    else if (r < 92) v = 31'h7FFF_FFFF;
    else v = 31'($urandom);
    return {1'($urandom_range(0, 1)), v};
  endfunction

  // command transfer; valid stays high when the next one follows at once
  task automatic send(input logic [1:0] cmd, input logic [31:0] now);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= now;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.take_command(cmd, now);
  endtask

  // hold off input until every owed result has come
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.owed_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
  endtask

  task automatic configure(input logic [31:0] iv, input logic [31:0] rc, input logic [31:0] td);
    write_reg(CfgInterval, iv);
    write_reg(CfgRepeat, rc);
    write_reg(CfgTrad, td);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed runs: start, then pulses with time moving forward
  task automatic run_phase(input int unsigned n_items);
    logic [31:0] cursor;
    logic [31:0] iv;
    int unsigned pick;
    cursor = $urandom;
    send(CmdStart, cursor);
    for (int unsigned i = 1; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (board.dead && pick < 60) begin
        send(CmdStart, cursor);
      end else if (pick < 6) begin
        send(CmdStart, cursor);
      end else if (pick < 9) begin
        send(CmdKill, $urandom);
      end else if (pick < 11) begin
        send(CmdUnknown, $urandom);
      end else if (pick < 14) begin
        send(CmdPulse, $urandom);
      end else begin
        iv = board.interval;
        if (iv <= 32'd1000) cursor = cursor + $urandom_range(0, iv * 12 + 3);
        else cursor = cursor + $urandom;
        send(CmdPulse, cursor);
      end
    end
  endtask

  // result side: check each transfer, then pick the next ready value
  initial begin
    int unsigned stall;
    stall = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_n && m_axis_tvalid_o && m_tready)
        board.match_result(m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
      if (stall != 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // run time limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[catchup_interval_timer_unit] ERROR");
      $finish;
    end
  end

  initial begin
    calm        = 1'b0;
    board       = new();
    rst_n     <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= CmdPulse;
    cfg_valid <= 1'b0;
    cfg_index <= CfgInterval;
    cfg_data  <= '0;
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // reset config: pulse while dead, unknown command, zero interval fires the full catch-up
    send(CmdPulse, 32'd0);
    send(CmdUnknown, 32'hFFFF_FFFF);
    send(CmdStart, 32'd0);
    send(CmdPulse, 32'd0);
    send(CmdKill, 32'd0);
    send(CmdPulse, 32'hFFFF_FFFF);
    drain();

    // unused register index, then catch-up cap and time wrap
    write_reg(CfgUnused, 32'hFFFF_FFFF);
    configure(32'd100, 32'd0, 32'd0);
    send(CmdStart, 32'd0);
    send(CmdPulse, 32'd99);
    send(CmdPulse, 32'd100);
    send(CmdPulse, 32'd5000);
    send(CmdPulse, 32'd1150);
    send(CmdStart, 32'hFFFF_FFC0);
    send(CmdPulse, 32'hFFFF_FFFF);
    drain();

    // largest interval with a repeat budget running out mid pulse
    configure(32'hFFFF_FFFF, 32'd3, 32'hFFFF_FFFE);
    send(CmdStart, 32'd1);
    send(CmdPulse, 32'd0);
    send(CmdPulse, 32'hFFFF_FFFF);
    send(CmdPulse, 32'hFFFF_FFFF);
    drain();

    // traditional mode with the largest repeat budget, restart after kill
    configure(32'd7, 32'hFFFF_FFFF, 32'd1);
    send(CmdStart, 32'd0);
    send(CmdPulse, 32'd6);
    send(CmdPulse, 32'd1000);
    send(CmdPulse, 32'd1006);
    send(CmdPulse, 32'd1007);
    send(CmdKill, 32'd1007);
    send(CmdStart, 32'd50);
    send(CmdPulse, 32'd57);
    drain();

    // random phases, every third one without idling
    for (int unsigned p = 0; p < 7; p++) begin
      calm = (p % 3 == 1);
      configure(pick_interval(), pick_repeat(), $urandom);
      run_phase(PhaseItems);
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.owed_q.size() == 0) begin
      $display("[catchup_interval_timer_unit] OK");
    end else begin
      $display("[catchup_interval_timer_unit] ERROR");
    end
    $finish;
  end

endmodule
